// File: rtl/core/mcf_pkg.sv
// Package for the metrics change filter: mode codes, sequencer states, scale constants.
// No dependencies.
package mcf_pkg;

	localparam logic [2:0] MODE_OFF = 3'd0;
	localparam logic [2:0] MODE_LOWPASS = 3'd1;
	localparam logic [2:0] MODE_THRESH = 3'd2;
	localparam logic [2:0] MODE_RATE = 3'd3;
	localparam logic [2:0] MODE_CHANGE = 3'd4;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_ALPHA = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_RATE = 2'd3;

	localparam logic [17:0] LEVEL_SCALE = 18'd140625;
	localparam logic [12:0] CENTROID_SCALE = 13'd6144;
	localparam logic [10:0] NOISE_SCALE = 11'd1600;
	localparam logic [6:0] HYST_NUM = 7'd49;
	localparam logic [6:0] HYST_DEN = 7'd100;

	// 19/20 scaled by 2^24 and rounded up; the floor is exact for 16-bit values.
	localparam logic [31:0] PEAK_DECAY_MUL = 32'd15938356;

	// Operand selects for the shared multiplier.
	typedef enum logic [3:0] {
		OP_DL2, OP_DS2, OP_DC, OP_DC2, OP_DN, OP_DN2, OP_T2, OP_LVL,
		OP_BA, OP_BB, OP_PEAK
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DL2, ST_DS2, ST_DSUM, ST_DC, ST_DC2, ST_DN, ST_DN2, ST_T2,
		ST_TLVL, ST_HD, ST_HN, ST_DEC,
		ST_B0A, ST_B0B, ST_B2A, ST_B2B, ST_B3A, ST_B3B, ST_B4A, ST_B4B,
		ST_PEAK, ST_OUT
	} state_t;

endpackage

// File: rtl/core/metrics_change_filter.sv
// Metrics change filter top level: configuration registers, held record, sequencer.
// Depends on mcf_pkg and mcf_mul.
//
// Usage: an input record is taken when in_valid is high and in_stall is low.
// The block then works on it alone through one shared registered 32x32
// multiplier and keeps in_stall high until the result is registered. In off,
// rate limit and undefined modes the result is registered with no multiplier
// steps; low-pass issues two products per blended field and one for the peak
// decay, and threshold and change detection issue dl^2, ds^2 and their
// scalings, dc, dn and their squares, T^2 and its scaling, one product issued
// per cycle. The next record is accepted only once the result is registered
// and the block is back in idle, so it never takes a new record before it is
// through with the last one. A result waits in the output register with
// out_valid high while out_stall is high; the block may take the next record
// meanwhile, but holds it at the end of its sequence, with in_stall high,
// until the waiting beat leaves. Reset clears configuration to its defaults,
// the held record, the passing flag and the last pass time. Configuration is
// written over cfg_valid/cfg_ready (ready always high) and must only be
// written while the block is idle. Distances are compared squared in exact
// integer arithmetic, so no root is taken.
module metrics_change_filter
	import mcf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        time_ms,
	input  logic [15:0]        current_level,
	input  logic [15:0]        peak_level,
	input  logic [15:0]        average_level,
	input  logic [14:0]        centroid_hz,
	input  logic [14:0]        bandwidth_hz,
	input  logic signed [15:0] noise_db,
	input  logic [15:0]        speech_prob,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               passed,
	output logic [15:0]        out_current_level,
	output logic [15:0]        out_peak_level,
	output logic [15:0]        out_average_level,
	output logic [14:0]        out_centroid_hz,
	output logic [14:0]        out_bandwidth_hz,
	output logic signed [15:0] out_noise_db,
	output logic [15:0]        out_speech_prob
);
	logic [2:0]  mode_q;
	logic [15:0] alpha_q, thresh_q, rate_q;
	logic [15:0] hcur_q, hpeak_q, havg_q, hnoise_q, hspeech_q;
	logic [14:0] hcent_q, hband_q;
	logic        passing_q;
	logic [31:0] last_q;
	logic [31:0] t_q;
	logic [15:0] icur_q, ipeak_q, iavg_q, inoise_q, ispeech_q;
	logic [14:0] icent_q, iband_q;
	logic [63:0] acc_q, t2_q;
	logic [31:0] tmp_q;
	logic [15:0] r0_q, r2_q;
	logic [14:0] r3_q, r4_q;
	state_t      state_q, state_d;
	op_t         op;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [15:0] dl, ds;
	logic [14:0] dc;
	logic [16:0] dn;
	logic signed [16:0] na, nb, ndiff;
	logic [31:0] elapsed;
	logic [16:0] ialpha;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			alpha_q <= 16'd0;
			thresh_q <= 16'd655;
			rate_q <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[2:0];
				REG_ALPHA:  alpha_q <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				REG_RATE:   rate_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign dl = (icur_q > hcur_q) ? icur_q - hcur_q : hcur_q - icur_q;
	assign ds = (ispeech_q > hspeech_q) ? ispeech_q - hspeech_q : hspeech_q - ispeech_q;
	assign dc = (icent_q > hcent_q) ? icent_q - hcent_q : hcent_q - icent_q;
	assign na = {inoise_q[15], inoise_q};
	assign nb = {hnoise_q[15], hnoise_q};
	assign ndiff = (na > nb) ? na - nb : nb - na;
	assign dn = ndiff[16:0];
	assign elapsed = t_q - last_q;
	assign ialpha = 17'h10000 - {1'b0, alpha_q};

	always_comb begin
		ma = 32'd0;
		mb = 32'd0;
		case (op)
			OP_DL2:  begin ma = {16'd0, dl}; mb = {16'd0, dl}; end
			OP_DS2:  begin ma = {16'd0, ds}; mb = {16'd0, ds}; end
			OP_DC:   begin ma = {17'd0, dc}; mb = {19'd0, CENTROID_SCALE}; end
			OP_DC2:  begin ma = tmp_q; mb = tmp_q; end
			OP_DN:   begin ma = {15'd0, dn}; mb = {21'd0, NOISE_SCALE}; end
			OP_DN2:  begin ma = tmp_q; mb = tmp_q; end
			OP_T2:   begin ma = {16'd0, thresh_q}; mb = {16'd0, thresh_q}; end
			OP_LVL:  begin ma = tmp_q; mb = {14'd0, LEVEL_SCALE}; end
			OP_PEAK: begin ma = {16'd0, hpeak_q}; mb = PEAK_DECAY_MUL; end
			OP_BA: begin
				ma = {16'd0, alpha_q};
				case (state_q)
					ST_B0A:  mb = {16'd0, hcur_q};
					ST_B2A:  mb = {16'd0, havg_q};
					ST_B3A:  mb = {17'd0, hcent_q};
					default: mb = {17'd0, hband_q};
				endcase
			end
			default: begin
				ma = {15'd0, ialpha};
				case (state_q)
					ST_B0B:  mb = {16'd0, icur_q};
					ST_B2B:  mb = {16'd0, iavg_q};
					ST_B3B:  mb = {17'd0, icent_q};
					default: mb = {17'd0, iband_q};
				endcase
			end
		endcase
	end

	mcf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(prod));

	// Each state issues one product; the product of the previous state is in prod.
	always_comb begin
		state_d = state_q;
		op = OP_DL2;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (mode_q)
					MODE_THRESH, MODE_CHANGE: state_d = ST_DL2;
					MODE_LOWPASS: state_d = ST_B0A;
					default: state_d = ST_OUT;
				endcase
			end
			ST_DL2:  begin op = OP_DL2; state_d = ST_DS2; end
			ST_DS2:  begin op = OP_DS2; state_d = ST_DSUM; end
			ST_DSUM: begin op = OP_LVL; state_d = ST_DC; end
			ST_DC:   begin op = OP_LVL; state_d = ST_DC2; end
			ST_DC2:  begin op = OP_DC; state_d = ST_DN; end
			ST_DN:   begin op = OP_DN; state_d = ST_DN2; end
			ST_DN2:  begin op = OP_DC2; state_d = ST_T2; end
			ST_T2:   begin op = OP_DN2; state_d = ST_TLVL; end
			ST_TLVL: begin op = OP_T2; state_d = ST_HD; end
			ST_HD:   begin op = OP_T2; state_d = ST_HN; end
			ST_HN:   begin op = OP_LVL; state_d = ST_DEC; end
			ST_DEC:  begin op = OP_LVL; state_d = ST_OUT; end
			ST_B0A:  begin op = OP_BA; state_d = ST_B0B; end
			ST_B0B:  begin op = OP_BB; state_d = ST_B2A; end
			ST_B2A:  begin op = OP_BA; state_d = ST_B2B; end
			ST_B2B:  begin op = OP_BB; state_d = ST_B3A; end
			ST_B3A:  begin op = OP_BA; state_d = ST_B3B; end
			ST_B3B:  begin op = OP_BB; state_d = ST_B4A; end
			ST_B4A:  begin op = OP_BA; state_d = ST_B4B; end
			ST_B4B:  begin op = OP_BB; state_d = ST_PEAK; end
			ST_PEAK: begin op = OP_PEAK; state_d = ST_OUT; end
			ST_OUT: begin
				// The peak product is reissued so it stays in prod while the output waits.
				op = OP_PEAK;
				if (!out_valid || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath accumulation. The squared distance stays below 2^56 and its hysteresis
	// multiple below 2^63, so 64 bits suffice.
	logic [63:0] blend_sum;
	assign blend_sum = {32'd0, tmp_q} + prod + 64'd32768;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			t_q <= time_ms; icur_q <= current_level; ipeak_q <= peak_level;
			iavg_q <= average_level; icent_q <= centroid_hz; iband_q <= bandwidth_hz;
			inoise_q <= noise_db; ispeech_q <= speech_prob;
			acc_q <= 64'd0;
		end
		case (state_q)
			ST_DS2:  tmp_q <= prod[31:0];
			ST_DSUM: tmp_q <= prod[31:0];
			ST_DC:   acc_q <= prod;
			ST_DC2:  acc_q <= acc_q + prod;
			ST_DN:   tmp_q <= prod[31:0];
			ST_DN2:  tmp_q <= prod[31:0];
			ST_T2:   acc_q <= acc_q + prod;
			ST_TLVL: acc_q <= acc_q + prod;
			ST_HD:   tmp_q <= prod[31:0];
			ST_DEC:  t2_q <= prod;
			ST_B0A, ST_B2A, ST_B3A, ST_B4A: ;
			ST_B0B, ST_B2B, ST_B3B, ST_B4B: tmp_q <= prod[31:0];
			default: ;
		endcase
		case (state_q)
			ST_B2A:  r0_q <= blend_sum[31:16];
			ST_B3A:  r2_q <= blend_sum[31:16];
			ST_B4A:  r3_q <= blend_sum[30:16];
			ST_PEAK: r4_q <= blend_sum[30:16];
			default: ;
		endcase
	end

	// Peak decay: floor(held*19/20) from the shared multiplier as (held*C)>>24.
	logic [15:0] decayed;
	assign decayed = prod[39:24];

	// Decision, done when the sequencer reaches ST_OUT.
	logic pass_d, hyst_pass, th_pass;
	logic [63:0] hd_full, hn_full;
	assign hd_full = acc_q * {57'd0, HYST_DEN};
	assign hn_full = t2_q * {57'd0, HYST_NUM};
	assign th_pass = acc_q >= t2_q;
	assign hyst_pass = hd_full >= hn_full;

	always_comb begin
		case (mode_q)
			MODE_THRESH: pass_d = th_pass;
			MODE_CHANGE: pass_d = passing_q ? hyst_pass : th_pass;
			MODE_RATE:   pass_d = elapsed >= {16'd0, rate_q};
			default:     pass_d = 1'b1;
		endcase
	end

	logic fire;
	assign fire = (state_q == ST_OUT) && (!out_valid || !out_stall);

	logic [15:0] res0, res1, res2;
	logic [14:0] res3, res4;
	always_comb begin
		if (mode_q == MODE_LOWPASS) begin
			res0 = r0_q; res2 = r2_q; res3 = r3_q; res4 = r4_q;
			res1 = (ipeak_q > decayed) ? ipeak_q : decayed;
		end else begin
			res0 = icur_q; res1 = ipeak_q; res2 = iavg_q; res3 = icent_q; res4 = iband_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcur_q <= '0; hpeak_q <= '0; havg_q <= '0; hcent_q <= '0; hband_q <= '0;
			hnoise_q <= '0; hspeech_q <= '0; passing_q <= 1'b0; last_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				out_valid <= 1'b1;
				if (mode_q == MODE_CHANGE) passing_q <= passing_q ? hyst_pass : th_pass;
				if (mode_q == MODE_RATE && pass_d) last_q <= t_q;
				if (pass_d) begin
					hcur_q <= res0; hpeak_q <= res1; havg_q <= res2; hcent_q <= res3;
					hband_q <= res4; hnoise_q <= inoise_q; hspeech_q <= ispeech_q;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			passed <= pass_d;
			out_current_level <= pass_d ? res0 : icur_q;
			out_peak_level <= pass_d ? res1 : ipeak_q;
			out_average_level <= pass_d ? res2 : iavg_q;
			out_centroid_hz <= pass_d ? res3 : icent_q;
			out_bandwidth_hz <= pass_d ? res4 : iband_q;
			out_noise_db <= inoise_q;
			out_speech_prob <= ispeech_q;
		end
	end
endmodule

// File: rtl/core/mcf_mul.sv
// Shared multiplier for the filter: one 32 by 32 product, registered.
// Depends on nothing.
module mcf_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= {32'd0, a} * {32'd0, b};
	end
endmodule

// File: rtl/core/mcf_checker.sv
// Port-level checks for the metrics change filter, bound to the top level.
// Depends on metrics_change_filter.
module mcf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic passed
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accept not followed by busy");
	a_no_out_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !($rose(out_valid) && !in_stall))
		else $error("result appeared while idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(passed))
		else $error("stalled result changed");
endmodule

bind metrics_change_filter mcf_checker u_mcf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .passed(passed)
);
